// ===== src/mpfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the mask projection face box unit.
package mpfb_pkg;

  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;

  // configuration register width and reset value
  localparam int CfgW = 9;
  localparam logic [CfgW-1:0] SizeReset = 9'd256;

  // width of each box coordinate on the result channel
  localparam int BoxW = 8;

  // result tdata is the box padded to whole bytes
  localparam int OutDataW = 40;
  localparam int InDataW  = 8;

  localparam int RegIdxW = 1;
  typedef enum logic [RegIdxW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // packed so that left lands in the lowest bits
  typedef struct packed {
    logic            bottom_found;
    logic            mask_found;
    logic [BoxW-1:0] bottom;
    logic [BoxW-1:0] top;
    logic [BoxW-1:0] right;
    logic [BoxW-1:0] left;
  } box_t;

  localparam int BoxBits = $bits(box_t);

endpackage

// ===== src/mask_projection_face_box_unit.sv =====
`timescale 1ns / 1ps
// Top level of the mask projection face box unit.
//
// Input channel s_axis_*: one mask pixel per transfer in raster order, row 0
// and column 0 first. Pixels are taken at one per cycle for the whole frame.
// After the last pixel of a frame, s_axis_tready drops while the box search
// runs: the column totals settle first; then, if any pixel is set, one column
// per cycle for the left and right walks from the peak column and one row per
// cycle for the bottom scan (H-1 down to 1) and the top scan (0 to H-1). The
// walks are bound by the single read port of the column total memory, the
// scans by the row prefix memory, read one row per cycle.
// Output channel m_axis_*: one box per frame. The box sits in an output
// register; while the receiver stalls it holds there and the next frame is
// still taken. A search that ends before the held box is taken waits for it.
// Configuration: cfg_we_i writes image_width (index 0) or image_height
// (index 1); write them only between frames. Reset clears the raster position
// and sets both sizes to 256. The mask memories are not cleared; every entry
// whose value a frame uses is written by that frame.
module mask_projection_face_box_unit #(
  parameter int MAX_WIDTH  = mpfb_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = mpfb_pkg::DefMaxHeight
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mask_bit
  input  logic [mpfb_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // box_left, box_right, box_top, box_bottom, mask_found, bottom_found
  output logic [mpfb_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [mpfb_pkg::RegIdxW-1:0]        cfg_idx_i,
  input  logic [mpfb_pkg::CfgW-1:0]           cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int NW = $clog2(MAX_WIDTH+1);
  localparam int TW = $clog2(MAX_HEIGHT+1);

  logic [mpfb_pkg::CfgW-1:0] width_q, height_q;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [CW-1:0]             last_col;
  logic [RW-1:0]             last_row;
  logic                      acc;
  logic                      pix;
  logic                      row_end;
  logic                      frame_end;
  logic                      in_last_row;

  logic [CW-1:0]             ct_addr;
  logic [TW-1:0]             ct_data;
  logic [TW-1:0]             peak_total;
  logic [CW-1:0]             peak_col;
  logic [RW-1:0]             pf_row;
  logic [CW-1:0]             pf_col_a, pf_col_b;
  logic [NW-1:0]             pf_data_a, pf_data_b;

  logic                      srch_idle;
  logic                      load;
  logic                      out_free;
  mpfb_pkg::box_t            box;
  mpfb_pkg::box_t            out_box_q;
  logic                      out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpfb_pkg::SizeReset;
      height_q <= mpfb_pkg::SizeReset;
    end else if (cfg_we_i) begin
      unique case (mpfb_pkg::reg_idx_e'(cfg_idx_i))
        mpfb_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        mpfb_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      last_col = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      last_row = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(height_q - 1'b1);
    end
  end

  assign s_axis_tready = srch_idle;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign pix           = s_axis_tdata[0];
  assign row_end       = col_q >= last_col;
  assign in_last_row   = row_q >= last_row;
  assign frame_end     = row_end && in_last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (row_end) begin
        col_d = '0;
        row_d = in_last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  mpfb_col_total #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_col_total (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .col_i        (col_q),
    .bit_i        (pix),
    .first_row_i  (row_q == '0),
    .last_row_i   (in_last_row),
    .rd_addr_i    (ct_addr),
    .rd_data_o    (ct_data),
    .peak_total_o (peak_total),
    .peak_col_o   (peak_col)
  );

  mpfb_row_prefix #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_row_prefix (
    .clk_i       (clk_i),
    .acc_i       (acc),
    .row_i       (row_q),
    .col_i       (col_q),
    .bit_i       (pix),
    .rd_row_i    (pf_row),
    .rd_col_a_i  (pf_col_a),
    .rd_col_b_i  (pf_col_b),
    .rd_data_a_o (pf_data_a),
    .rd_data_b_o (pf_data_b)
  );

  mpfb_search #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (acc && frame_end),
    .last_col_i   (last_col),
    .last_row_i   (last_row),
    .peak_total_i (peak_total),
    .peak_col_i   (peak_col),
    .ct_addr_o    (ct_addr),
    .ct_data_i    (ct_data),
    .pf_row_o     (pf_row),
    .pf_col_a_o   (pf_col_a),
    .pf_col_b_o   (pf_col_b),
    .pf_data_a_i  (pf_data_a),
    .pf_data_b_i  (pf_data_b),
    .out_free_i   (out_free),
    .idle_o       (srch_idle),
    .load_o       (load),
    .box_o        (box)
  );

  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_box_q <= box;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(mpfb_pkg::OutDataW - mpfb_pkg::BoxBits)'(0), out_box_q};

endmodule

// ===== src/mpfb_col_total.sv =====
`timescale 1ns / 1ps
// Column total memory: read-modify-write per pixel and running peak search.
module mpfb_col_total #(
  parameter int MAX_WIDTH  = mpfb_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = mpfb_pkg::DefMaxHeight
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      col_i,
  input  logic                              bit_i,
  input  logic                              first_row_i,
  input  logic                              last_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_i,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]   rd_data_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]   peak_total_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      peak_col_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int TW = $clog2(MAX_HEIGHT+1);

  logic [TW-1:0] mem [MAX_WIDTH];

  logic [CW-1:0] addr;
  logic [TW-1:0] rd_q;
  logic          p_vld_q;
  logic [CW-1:0] p_col_q;
  logic          p_bit_q;
  logic          p_first_q;
  logic          p_last_q;
  logic          fwd_q;
  logic [TW-1:0] fwd_val_q;
  logic [TW-1:0] base;
  logic [TW-1:0] val;
  logic [TW-1:0] peak_q;
  logic [CW-1:0] peak_col_q;

  assign addr = acc_i ? col_i : rd_addr_i;

  always_comb begin
    base = fwd_q ? fwd_val_q : rd_q;
    // the first row of a frame starts each column from zero
    val  = (p_first_q ? '0 : base) + TW'(p_bit_q);
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr];
    if (p_vld_q) begin
      mem[p_col_q] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    p_col_q   <= col_i;
    p_bit_q   <= bit_i;
    p_first_q <= first_row_i;
    p_last_q  <= last_row_i;
    fwd_val_q <= val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q    <= 1'b0;
      fwd_q      <= 1'b0;
      peak_q     <= '0;
      peak_col_q <= '0;
    end else begin
      p_vld_q <= acc_i;
      // a one-column frame reads the entry that is being written back
      fwd_q   <= acc_i && p_vld_q && (col_i == p_col_q);
      if (p_vld_q && p_last_q) begin
        if (p_col_q == '0 || val > peak_q) begin
          peak_q     <= val;
          peak_col_q <= p_col_q;
        end
      end
    end
  end

  assign rd_data_o    = rd_q;
  assign peak_total_o = peak_q;
  assign peak_col_o   = peak_col_q;

endmodule

// ===== src/mpfb_row_prefix.sv =====
`timescale 1ns / 1ps
// Row prefix count memory: per pixel the set bits of its row up to and including it.
module mpfb_row_prefix #(
  parameter int MAX_WIDTH  = mpfb_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = mpfb_pkg::DefMaxHeight
) (
  input  logic                             clk_i,
  input  logic                             acc_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     col_i,
  input  logic                             bit_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    rd_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     rd_col_a_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     rd_col_b_i,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   rd_data_a_o,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   rd_data_b_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int NW    = $clog2(MAX_WIDTH+1);
  localparam int Depth = 2 ** (RW + CW);

  logic [NW-1:0] mem [Depth];

  logic [NW-1:0] run_q;
  logic [NW-1:0] sum;
  logic [NW-1:0] rd_a_q;
  logic [NW-1:0] rd_b_q;

  assign sum = (col_i == '0 ? '0 : run_q) + NW'(bit_i);

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mem[{row_i, col_i}] <= sum;
      run_q               <= sum;
    end
    rd_a_q <= mem[{rd_row_i, rd_col_a_i}];
    rd_b_q <= mem[{rd_row_i, rd_col_b_i}];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== src/mpfb_search.sv =====
`timescale 1ns / 1ps
// Box search sequencer: column walks, bottom scan and top scan over the two memories.
module mpfb_search #(
  parameter int MAX_WIDTH  = mpfb_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = mpfb_pkg::DefMaxHeight
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     last_col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]    last_row_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  peak_total_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     peak_col_i,
  output logic [$clog2(MAX_WIDTH)-1:0]     ct_addr_o,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  ct_data_i,
  output logic [$clog2(MAX_HEIGHT)-1:0]    pf_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     pf_col_a_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     pf_col_b_o,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   pf_data_a_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   pf_data_b_i,
  input  logic                             out_free_i,
  output logic                             idle_o,
  output logic                             load_o,
  output mpfb_pkg::box_t                   box_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int NW  = $clog2(MAX_WIDTH+1);
  localparam int TW  = $clog2(MAX_HEIGHT+1);
  localparam int IW  = (CW > RW) ? CW : RW;
  localparam int MW1 = (NW > TW) ? NW : TW;
  localparam int MW2 = (MW1 > RW) ? MW1 : RW;
  localparam int KW  = MW2 + 5;

  localparam logic [KW-1:0] K3  = KW'(3);
  localparam logic [KW-1:0] K5  = KW'(5);
  localparam logic [KW-1:0] K6  = KW'(6);
  localparam logic [KW-1:0] K7  = KW'(7);
  localparam logic [KW-1:0] K10 = KW'(10);
  localparam logic [KW-1:0] K17 = KW'(17);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DRAIN  = 8'b0000_0010,
    S_START  = 8'b0000_0100,
    S_WALK_L = 8'b0000_1000,
    S_WALK_R = 8'b0001_0000,
    S_BOTTOM = 8'b0010_0000,
    S_TOP    = 8'b0100_0000,
    S_LOAD   = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic          vld_q, vld_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] chk_q;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;
  logic [RW-1:0] top_q, top_d;
  logic [RW-1:0] bottom_q, bottom_d;
  logic          bf_q, bf_d;
  logic          found_q, found_d;

  logic [CW-1:0] span;
  logic [NW-1:0] cnt_a;
  logic [NW-1:0] row_cnt;
  logic          l_stop, r_stop, bot_hit, top_hit;
  logic [IW-1:0] last_col_w, last_row_w;

  assign last_col_w = IW'(last_col_i);
  assign last_row_w = IW'(last_row_i);

  assign ct_addr_o  = idx_q[CW-1:0];
  assign pf_row_o   = idx_q[RW-1:0];
  // left minus one wraps at column zero; that read is then masked
  assign pf_col_a_o = left_q - 1'b1;
  assign pf_col_b_o = (state_q == S_BOTTOM) ? right_q - 1'b1 : right_q;

  always_comb begin
    span    = right_q - left_q;
    cnt_a   = (left_q == '0) ? '0 : pf_data_a_i;
    // the bottom range is half open, so an empty box counts nothing
    if (state_q == S_BOTTOM && right_q == left_q) begin
      row_cnt = '0;
    end else begin
      row_cnt = pf_data_b_i - cnt_a;
    end
    l_stop  = KW'(ct_data_i) * K5 < KW'(peak_total_i);
    r_stop  = KW'(ct_data_i) * K10 < KW'(peak_total_i) * K3;
    bot_hit = KW'(row_cnt) * K10 >= KW'(span) * K7;
    top_hit = (KW'(row_cnt) * K10 >= KW'(span) * K6) && (bottom_q >= top_q) &&
              (KW'(bottom_q - top_q) * K10 >= KW'(span) * K17);
  end

  always_comb begin
    state_d  = state_q;
    vld_d    = vld_q;
    idx_d    = idx_q;
    left_d   = left_q;
    right_d  = right_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    bf_d     = bf_q;
    found_d  = found_q;
    load_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the last column total land before reading the peak
        state_d = S_START;
      end
      S_START: begin
        vld_d    = 1'b0;
        idx_d    = IW'(peak_col_i);
        left_d   = '0;
        right_d  = '0;
        top_d    = '0;
        bottom_d = '0;
        bf_d     = 1'b0;
        found_d  = (peak_total_i != '0);
        state_d  = (peak_total_i != '0) ? S_WALK_L : S_LOAD;
      end
      S_WALK_L: begin
        vld_d = 1'b1;
        if (idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end
        if (vld_q && (l_stop || chk_q == '0)) begin
          left_d  = CW'(chk_q);
          idx_d   = IW'(peak_col_i);
          vld_d   = 1'b0;
          state_d = S_WALK_R;
        end
      end
      S_WALK_R: begin
        vld_d = 1'b1;
        if (idx_q != last_col_w) begin
          idx_d = idx_q + 1'b1;
        end
        if (vld_q && (r_stop || chk_q == last_col_w)) begin
          right_d = CW'(chk_q);
          vld_d   = 1'b0;
          if (last_row_i == '0) begin
            idx_d   = '0;
            state_d = S_TOP;
          end else begin
            idx_d   = last_row_w;
            state_d = S_BOTTOM;
          end
        end
      end
      S_BOTTOM: begin
        vld_d = 1'b1;
        if (idx_q != IW'(1)) begin
          idx_d = idx_q - 1'b1;
        end
        if (vld_q) begin
          if (bot_hit) begin
            bottom_d = RW'(chk_q);
            bf_d     = 1'b1;
            idx_d    = '0;
            vld_d    = 1'b0;
            state_d  = S_TOP;
          end else if (chk_q == IW'(1)) begin
            idx_d    = '0;
            vld_d    = 1'b0;
            state_d  = S_TOP;
          end
        end
      end
      S_TOP: begin
        vld_d = 1'b1;
        if (idx_q != last_row_w) begin
          idx_d = idx_q + 1'b1;
        end
        if (vld_q) begin
          if (top_hit) begin
            top_d = RW'(chk_q);
          end
          if (chk_q == last_row_w) begin
            vld_d   = 1'b0;
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // hold the box until the output register is free
        if (out_free_i) begin
          load_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    chk_q    <= idx_q;
    left_q   <= left_d;
    right_q  <= right_d;
    top_q    <= top_d;
    bottom_q <= bottom_d;
    bf_q     <= bf_d;
    found_q  <= found_d;
  end

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    box_o.left         = mpfb_pkg::BoxW'(left_q);
    box_o.right        = mpfb_pkg::BoxW'(right_q);
    box_o.top          = mpfb_pkg::BoxW'(top_q);
    box_o.bottom       = mpfb_pkg::BoxW'(bottom_q);
    box_o.mask_found   = found_q;
    box_o.bottom_found = bf_q;
  end

endmodule

// ===== src/mpfb_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the mask projection face box unit, bound to the top level.
module mpfb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mpfb_pkg::OutDataW-1:0]   m_axis_tdata
);

  // a stalled box holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty mask gives an all-zero box
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[33:0] == 34'd0)
    else $error("empty mask with nonzero box");

  // a missing bottom row leaves bottom at zero, and a bottom needs a mask
  a_bottom_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33] || m_axis_tdata[31:24] == 8'd0) &&
                      (!m_axis_tdata[33] || m_axis_tdata[32]))
    else $error("bottom flag inconsistent with box");

  // input stalls only right after a transfer; the check does not test that it closed a frame
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input stalled without a closing transfer");

endmodule

bind mask_projection_face_box_unit mpfb_checker u_mpfb_checker (.*);

// ===== tb/tb_mask_projection_face_box_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the mask projection face box unit.
module tb_mask_projection_face_box_unit;

  localparam int MaxW          = mpfb_pkg::DefMaxWidth;
  localparam int MaxH          = mpfb_pkg::DefMaxHeight;
  localparam int InDataW       = mpfb_pkg::InDataW;
  localparam int OutDataW      = mpfb_pkg::OutDataW;
  localparam int RegIdxW       = mpfb_pkg::RegIdxW;
  localparam int CfgW          = mpfb_pkg::CfgW;
  localparam int BoxW          = mpfb_pkg::BoxW;
  localparam int BoxBits       = mpfb_pkg::BoxBits;
  localparam int TotalPixels   = 1450;
  localparam int SearchLatency = MaxW + 2 * MaxH + 16;
  localparam int CycleLimit    = 400_000;
  localparam int HoldCycles    = 600;

  typedef mpfb_pkg::box_t box_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i     = mpfb_pkg::REG_IMAGE_WIDTH;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  mask_projection_face_box_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: stored frame, raster position and size registers.
  bit              frame_pixels [MaxH][MaxW];
  int unsigned     raster_col;
  int unsigned     raster_row;
  logic [CfgW-1:0] width_reg  = mpfb_pkg::SizeReset;
  logic [CfgW-1:0] height_reg = mpfb_pkg::SizeReset;

  box_t expected_boxes [$];
  int   error_count;
  int   boxes_seen;
  int   pixels_sent;
  int   cycle_count;
  int   burst_left = 8;
  bit   sender_offering;
  bit   pressure_on = 1'b0;
  logic holding_off = 1'b0;

  typedef struct {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
    logic [15:0]     bits;   // pixel k of the frame in raster order
    bit              typed;
    box_t            box;
  } frame_case_t;

  frame_case_t directed_frames [6] = '{
    // zero sizes act as a 1x1 frame; empty mask
    '{width: 9'd0, height: 9'd0, bits: 16'h0000, typed: 1'b1, box: '0},
    // single set pixel
    '{width: 9'd0, height: 9'd0, bits: 16'h0001, typed: 1'b1,
      box: '{mask_found: 1'b1, default: '0}},
    // single row frame: bottom scan sees no rows
    '{width: 9'd4, height: 9'd1, bits: 16'h0006, typed: 1'b0, box: '0},
    // zero box width: every row meets the bottom test
    '{width: 9'd1, height: 9'd4, bits: 16'h000d, typed: 1'b0, box: '0},
    // no bottom row qualifies
    '{width: 9'd3, height: 9'd3, bits: 16'h0002, typed: 1'b0, box: '0},
    '{width: 9'd2, height: 9'd2, bits: 16'h000f, typed: 1'b0, box: '0}
  };

  function automatic int unsigned effective_size(logic [CfgW-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic int unsigned span_count(int unsigned row, int unsigned from,
                                             int unsigned to_excl);
    int unsigned c;
    c = 0;
    for (int unsigned x = from; x < to_excl; x++) c += frame_pixels[row][x];
    return c;
  endfunction

  function automatic box_t predict_face_box(int unsigned w, int unsigned h);
    box_t        b;
    int unsigned col_total [MaxW];
    int unsigned peak_total, peak_col, left, right, bottom, top, d, c;
    int          gap;
    b = '0;
    peak_total = 0;
    peak_col = 0;
    bottom = 0;
    top = 0;
    for (int unsigned j = 0; j < w; j++) begin
      c = 0;
      for (int unsigned i = 0; i < h; i++) c += frame_pixels[i][j];
      col_total[j] = c;
      if (c > peak_total) begin
        peak_total = c;
        peak_col = j;
      end
    end
    if (peak_total == 0) return b;
    // walk out from the first peak column to the 0.2 and 0.3 thresholds
    left = peak_col;
    while (!(5 * col_total[left] < peak_total || left == 0)) left--;
    right = peak_col;
    while (!(10 * col_total[right] < 3 * peak_total || right == w - 1)) right++;
    d = right - left;
    for (int i = int'(h) - 1; i > 0; i--) begin
      if (10 * span_count(i, left, right) >= 7 * d) begin
        bottom = i;
        b.bottom_found = 1'b1;
        break;
      end
    end
    // top compares against its own running value
    for (int unsigned i = 0; i < h; i++) begin
      c = span_count(i, left, right + 1);
      gap = int'(bottom) - int'(top);
      if (10 * c >= 6 * d && 10 * gap >= 17 * int'(d)) top = i;
    end
    b.left = left[BoxW-1:0];
    b.right = right[BoxW-1:0];
    b.top = top[BoxW-1:0];
    b.bottom = bottom[BoxW-1:0];
    b.mask_found = 1'b1;
    return b;
  endfunction

  function automatic void take_pixel(input logic mask_bit, output logic frame_done,
                                     output box_t frame_box);
    int unsigned w, h;
    w = effective_size(width_reg, MaxW);
    h = effective_size(height_reg, MaxH);
    frame_done = 1'b0;
    frame_box = '0;
    frame_pixels[raster_row][raster_col] = mask_bit;
    if (raster_col >= w - 1) begin
      raster_col = 0;
      if (raster_row >= h - 1) begin
        raster_row = 0;
        frame_done = 1'b1;
        frame_box = predict_face_box(w, h);
      end else begin
        raster_row++;
      end
    end else begin
      raster_col++;
    end
  endfunction

  // Idle between bursts first, so a finished frame returns at its transfer.
  task automatic send_pixel(input logic mask_bit, output logic frame_done,
                            output box_t frame_box);
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      sender_offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW - 1){1'b0}}, mask_bit};
    sender_offering = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
    take_pixel(mask_bit, frame_done, frame_box);
    burst_left--;
  endtask

  task automatic write_sizes(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= mpfb_pkg::REG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= mpfb_pkg::REG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = w;
    height_reg = h;
  endtask

  // Drop valid and hold until every box has come back.
  task automatic wait_idle();
    if (sender_offering) begin
      s_axis_tvalid <= 1'b0;
      sender_offering = 1'b0;
    end
    while (expected_boxes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Frame styles: random density, rectangle with noise, all clear, all set.
  task automatic send_frame();
    int unsigned w, h, style, density, noise, r0, r1, c0, c1;
    logic        b, frame_done;
    box_t        frame_box;
    w = effective_size(width_reg, MaxW);
    h = effective_size(height_reg, MaxH);
    style = $urandom_range(0, 8);
    density = $urandom_range(0, 100);
    noise = $urandom_range(0, 10);
    r0 = $urandom_range(0, h - 1);
    r1 = $urandom_range(r0, h - 1);
    c0 = $urandom_range(0, w - 1);
    c1 = $urandom_range(c0, w - 1);
    do begin
      case (style)
        0, 1:    b = ($urandom_range(0, 99) < density);
        7:       b = 1'b0;
        8:       b = 1'b1;
        default: begin
          b = (raster_row >= r0 && raster_row <= r1 && raster_col >= c0 && raster_col <= c1);
          if ($urandom_range(0, 99) < noise) b = !b;
        end
      endcase
      send_pixel(b, frame_done, frame_box);
    end while (!frame_done);
    expected_boxes.push_back(frame_box);
  endtask

  function automatic void report_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // Receiver: rotate a 16-bit stall pattern and replace it when pattern_left runs out.
  logic [15:0] stall_pattern = 16'hffff;
  int          pattern_left;
  int          pattern_pos;

  always @(posedge clk_i) begin
    if (pattern_left == 0) begin
      stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
      pattern_left = 64;
    end
    pattern_left--;
    pattern_pos = (pattern_pos + 1) % 16;
    m_axis_tready <= holding_off ? 1'b0 : stall_pattern[pattern_pos];
  end

  // Hold the receiver off long enough for the input to back up.
  initial begin
    while (!pressure_on) @(posedge clk_i);
    holding_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holding_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    box_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = box_t'(m_axis_tdata[BoxBits-1:0]);
      boxes_seen++;
      if (expected_boxes.size() == 0) begin
        report_failure($sformatf("box transfer with none expected: %h", m_axis_tdata));
      end else begin
        want = expected_boxes.pop_front();
        if (got.left !== want.left || got.right !== want.right || got.top !== want.top ||
            got.bottom !== want.bottom || got.mask_found !== want.mask_found ||
            got.bottom_found !== want.bottom_found ||
            m_axis_tdata[OutDataW-1:BoxBits] !== '0) begin
          report_failure($sformatf(
            "box %0d: expected L%0d R%0d T%0d B%0d mf%0b bf%0b, got L%0d R%0d T%0d B%0d mf%0b bf%0b pad %h",
            boxes_seen, want.left, want.right, want.top, want.bottom, want.mask_found,
            want.bottom_found, got.left, got.right, got.top, got.bottom, got.mask_found,
            got.bottom_found, m_axis_tdata[OutDataW-1:BoxBits]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int   k, phase;
    logic frame_done;
    box_t frame_box;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_frames[n]) begin
      write_sizes(directed_frames[n].width, directed_frames[n].height);
      k = 0;
      do begin
        send_pixel(directed_frames[n].bits[k], frame_done, frame_box);
        k++;
      end while (!frame_done);
      expected_boxes.push_back(directed_frames[n].typed ? directed_frames[n].box : frame_box);
      wait_idle();
    end

    // Mostly small frames; two phases take the widest and the tallest frame.
    phase = 0;
    while (pixels_sent < TotalPixels) begin
      if (phase == 2) begin
        write_sizes(9'd511, 9'd1);
        send_frame();
      end else if (phase == 4) begin
        // frames keep coming while the receiver is held off
        write_sizes(9'd4, 9'd4);
        pressure_on = 1'b1;
        repeat (6) send_frame();
      end else if (phase == 6) begin
        write_sizes(9'd1, 9'd256);
        send_frame();
      end else begin
        write_sizes(CfgW'($urandom_range(0, 12)), CfgW'($urandom_range(0, 12)));
        repeat ($urandom_range(1, 4)) if (pixels_sent < TotalPixels) send_frame();
      end
      wait_idle();
      phase++;
    end

    repeat (SearchLatency) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mpfb_pkg.sv
src/mpfb_col_total.sv
src/mpfb_row_prefix.sv
src/mpfb_search.sv
src/mask_projection_face_box_unit.sv
src/mpfb_checker.sv
tb/tb_mask_projection_face_box_unit.sv
